FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; expects clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/ffira_pkg.sv
// Package for the first-fit interval row allocator.
// Command and status codes, sequencer states and interface structs; no dependencies.
package ffira_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_PLACED   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_READ     = 2'd2;
  localparam logic [1:0] ST_CLEARED  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_DAYS = 1'b1;

  localparam logic [4:0] RESULT_CAP = 5'd16;
  localparam logic [4:0] ROWS_RESET = 5'd16;
  localparam logic [6:0] DAYS_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_SCAN,
    S_CHECK,
    S_MARK
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic       strobe;
    logic [1:0] status;
    logic [3:0] row;
    logic [7:0] owner_out;
    logic       last;
  } res_t;

endpackage

FILE: rtl/core/ffira_mem.sv
// Occupancy table storage: single-port synchronous RAM, registered read.
// Uses ffira_pkg::mem_ctl_t.
module ffira_mem #(
  parameter int AW = 10,
  parameter int DW = 8
) (
  input  logic                clk,
  input  ffira_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]       addr,
  input  logic [DW-1:0]       wdata,
  output logic [DW-1:0]       rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/ffira_ctrl.sv
// Request sequencer: clear sweep, cell read, first-fit row scan and day marking.
// Uses ffira_pkg; drives the table RAM in ffira_mem.
module ffira_ctrl #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_DAYS    = 64,
  parameter int OWNER_WIDTH = 8,
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int DW     = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1,
  localparam int AW     = RW + DW,
  localparam int ROW_CW = ($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5,
  localparam int DAY_CW = ($clog2(MAX_DAYS + 1) > 7) ? $clog2(MAX_DAYS + 1) : 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             cmd,
  input  logic [7:0]             owner,
  input  logic [5:0]             start_day,
  input  logic [6:0]             end_day,
  input  logic [4:0]             unit_count,
  input  logic [3:0]             read_row,
  input  logic [ROW_CW-1:0]      rows_eff,
  input  logic [DAY_CW-1:0]      days_eff,
  output logic                   busy,
  output ffira_pkg::mem_ctl_t    mem_ctl,
  output logic [AW-1:0]          mem_addr,
  output logic [OWNER_WIDTH-1:0] mem_wdata,
  input  logic [OWNER_WIDTH-1:0] mem_rdata,
  output ffira_pkg::res_t        res
);

  ffira_pkg::state_t state, state_next;

  logic [ROW_CW-1:0]      scan_row;
  logic [DAY_CW-1:0]      cur_day;
  logic [DAY_CW-1:0]      req_start;
  logic [DAY_CW-1:0]      req_end;
  logic [OWNER_WIDTH-1:0] req_owner;
  logic [4:0]             units_left;
  logic [AW-1:0]          clr_addr;
  logic                   clr_report;

  logic [ROW_CW-1:0] rrow_ext;
  logic [DAY_CW-1:0] sday_ext;
  logic [DAY_CW-1:0] eday_ext;
  logic [DAY_CW-1:0] day_inc;
  logic [31:0]       owner_ext;
  logic [31:0]       rdata_ext;
  logic              read_ok;
  logic              start_ok;
  logic              cell_free;
  logic              mark_done;
  logic              last_unit;

  assign rrow_ext  = ROW_CW'(read_row);
  assign sday_ext  = DAY_CW'(start_day);
  assign eday_ext  = DAY_CW'(end_day);
  assign day_inc   = DAY_CW'(cur_day + DAY_CW'(1));
  assign owner_ext = 32'(owner);
  assign rdata_ext = 32'(mem_rdata);
  assign read_ok   = (rrow_ext < rows_eff) && (sday_ext < days_eff);
  assign start_ok  = sday_ext < days_eff;
  assign cell_free = mem_rdata == '0;
  assign mark_done = day_inc >= req_end;
  assign last_unit = units_left == 5'd1;
  assign busy      = state != ffira_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ffira_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            ffira_pkg::CMD_CLEAR: state_next = ffira_pkg::S_CLEAR;
            ffira_pkg::CMD_READ: begin
              if (read_ok) state_next = ffira_pkg::S_READ;
            end
            ffira_pkg::CMD_ALLOC: begin
              if (unit_count != '0 && start_ok) state_next = ffira_pkg::S_SCAN;
            end
            default: state_next = ffira_pkg::S_IDLE;
          endcase
        end
      end
      ffira_pkg::S_CLEAR: begin
        if (clr_addr == '1) state_next = ffira_pkg::S_IDLE;
      end
      ffira_pkg::S_READ: state_next = ffira_pkg::S_IDLE;
      ffira_pkg::S_SCAN: begin
        state_next = (scan_row >= rows_eff) ? ffira_pkg::S_IDLE : ffira_pkg::S_CHECK;
      end
      ffira_pkg::S_CHECK: begin
        if (!cell_free) begin
          state_next = ffira_pkg::S_SCAN;
        end else if (req_start < req_end) begin
          state_next = ffira_pkg::S_MARK;
        end else begin
          state_next = last_unit ? ffira_pkg::S_IDLE : ffira_pkg::S_SCAN;
        end
      end
      ffira_pkg::S_MARK: begin
        if (mark_done) state_next = last_unit ? ffira_pkg::S_IDLE : ffira_pkg::S_SCAN;
      end
      default: state_next = ffira_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = '0;
    mem_wdata = '0;
    res       = '0;
    case (state)
      ffira_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            ffira_pkg::CMD_READ: begin
              mem_ctl.rd_en = read_ok;
              mem_addr      = {rrow_ext[RW-1:0], sday_ext[DW-1:0]};
              if (!read_ok) begin
                res.strobe = 1'b1;
                res.status = ffira_pkg::ST_READ;
                res.last   = 1'b1;
              end
            end
            ffira_pkg::CMD_ALLOC: begin
              if (unit_count != '0 && !start_ok) begin
                res.strobe = 1'b1;
                res.status = ffira_pkg::ST_OVERFLOW;
                res.last   = 1'b1;
              end
            end
            default: res = '0;
          endcase
        end
      end
      ffira_pkg::S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_addr      = clr_addr;
        if (clr_addr == '1 && clr_report) begin
          res.strobe = 1'b1;
          res.status = ffira_pkg::ST_CLEARED;
          res.last   = 1'b1;
        end
      end
      ffira_pkg::S_READ: begin
        res.strobe    = 1'b1;
        res.status    = ffira_pkg::ST_READ;
        res.owner_out = rdata_ext[7:0];
        res.last      = 1'b1;
      end
      ffira_pkg::S_SCAN: begin
        if (scan_row >= rows_eff) begin
          res.strobe = 1'b1;
          res.status = ffira_pkg::ST_OVERFLOW;
          res.last   = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = {scan_row[RW-1:0], req_start[DW-1:0]};
        end
      end
      ffira_pkg::S_CHECK: begin
        if (cell_free && !(req_start < req_end)) begin
          res.strobe = 1'b1;
          res.status = ffira_pkg::ST_PLACED;
          res.row    = scan_row[3:0];
          res.last   = last_unit;
        end
      end
      ffira_pkg::S_MARK: begin
        mem_ctl.wr_en = 1'b1;
        mem_addr      = {scan_row[RW-1:0], cur_day[DW-1:0]};
        mem_wdata     = req_owner;
        if (mark_done) begin
          res.strobe = 1'b1;
          res.status = ffira_pkg::ST_PLACED;
          res.row    = scan_row[3:0];
          res.last   = last_unit;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffira_pkg::S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      units_left <= '0;
    end else begin
      state <= state_next;
      case (state)
        ffira_pkg::S_IDLE: begin
          if (start) begin
            req_start  <= sday_ext;
            req_end    <= (eday_ext > days_eff) ? days_eff : eday_ext;
            req_owner  <= owner_ext[OWNER_WIDTH-1:0];
            units_left <= (unit_count > ffira_pkg::RESULT_CAP) ? ffira_pkg::RESULT_CAP
                                                                : unit_count;
            scan_row   <= '0;
            clr_addr   <= '0;
            clr_report <= 1'b1;
          end
        end
        ffira_pkg::S_CLEAR: clr_addr <= AW'(clr_addr + AW'(1));
        ffira_pkg::S_SCAN: begin
          if (scan_row >= rows_eff) units_left <= '0;
        end
        ffira_pkg::S_CHECK: begin
          if (!cell_free) begin
            scan_row <= ROW_CW'(scan_row + ROW_CW'(1));
          end else begin
            cur_day <= req_start;
            if (!(req_start < req_end)) units_left <= 5'(units_left - 5'd1);
          end
        end
        ffira_pkg::S_MARK: begin
          cur_day <= day_inc;
          if (mark_done) units_left <= 5'(units_left - 5'd1);
        end
        default: clr_addr <= clr_addr;
      endcase
    end
  end

endmodule

FILE: rtl/core/first_fit_interval_row_allocator_top.sv
// Top level of the first-fit interval row allocator: config registers, result register.
// Uses ffira_pkg, ffira_ctrl, ffira_mem and assert_macros.svh.

// One request at a time, taken when start is high and busy is low. Results come
// on strobe in the cycle after they are formed, one cycle each, and cannot be
// held off by the receiver. The occupancy table is a single-port RAM with at
// most one access per cycle. A read inside the rows and days in use starts the
// RAM read in the accepting cycle and gives its result from the read state. An
// allocation examines, per unit, rows at the start day in the scan and check
// states (the scan resumes at the row last given), then marks its days in the
// mark state; an overflow result ends it when the rows run out. A clear takes
// the accepting cycle plus a sweep over the whole RAM, one entry per cycle, and
// the same sweep runs after reset with busy high and no result. An allocation
// whose start day lies outside the days in use, a read outside the rows or
// days in use, zero units and unknown commands finish in the accepting cycle.
`include "assert_macros.svh"

module first_fit_interval_row_allocator_top #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_DAYS    = 64,
  parameter int OWNER_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] owner,
  input  logic [5:0] start_day,
  input  logic [6:0] end_day,
  input  logic [4:0] unit_count,
  input  logic [3:0] read_row,
  input  logic       cfg_wen,
  input  logic       cfg_addr,
  input  logic [6:0] cfg_data,
  output logic       strobe,
  output logic [1:0] status,
  output logic [3:0] row,
  output logic [7:0] owner_out,
  output logic       last
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW     = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int AW     = RW + DW;
  localparam int ROW_CW = ($clog2(MAX_ROWS + 1) > 5) ? $clog2(MAX_ROWS + 1) : 5;
  localparam int DAY_CW = ($clog2(MAX_DAYS + 1) > 7) ? $clog2(MAX_DAYS + 1) : 7;

  logic [4:0] rows_in_use;
  logic [6:0] days_in_use;

  logic [ROW_CW-1:0]      rows_ext;
  logic [DAY_CW-1:0]      days_ext;
  logic [ROW_CW-1:0]      rows_eff;
  logic [DAY_CW-1:0]      days_eff;
  ffira_pkg::mem_ctl_t    mem_ctl;
  logic [AW-1:0]          mem_addr;
  logic [OWNER_WIDTH-1:0] mem_wdata;
  logic [OWNER_WIDTH-1:0] mem_rdata;
  ffira_pkg::res_t        res;

  assign rows_ext = ROW_CW'(rows_in_use);
  assign days_ext = DAY_CW'(days_in_use);
  assign rows_eff = (rows_ext > ROW_CW'(MAX_ROWS)) ? ROW_CW'(MAX_ROWS) : rows_ext;
  assign days_eff = (days_ext > DAY_CW'(MAX_DAYS)) ? DAY_CW'(MAX_DAYS) : days_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ffira_pkg::ROWS_RESET;
      days_in_use <= ffira_pkg::DAYS_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        ffira_pkg::REG_ROWS: rows_in_use <= cfg_data[4:0];
        ffira_pkg::REG_DAYS: days_in_use <= cfg_data;
        default: rows_in_use <= rows_in_use;
      endcase
    end
  end

  ffira_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_DAYS    (MAX_DAYS),
    .OWNER_WIDTH (OWNER_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .owner      (owner),
    .start_day  (start_day),
    .end_day    (end_day),
    .unit_count (unit_count),
    .read_row   (read_row),
    .rows_eff   (rows_eff),
    .days_eff   (days_eff),
    .busy       (busy),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .res        (res)
  );

  ffira_mem #(
    .AW (AW),
    .DW (OWNER_WIDTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.strobe;
    end
    status    <= res.status;
    row       <= res.row;
    owner_out <= res.owner_out;
    last      <= res.last;
  end

  `ASSERT_NEXT(a_clear_goes_busy, start && !busy && cmd == ffira_pkg::CMD_CLEAR, busy,
               "clear request did not start the sweep")
  `ASSERT_IMPL(a_single_result_last, strobe && status != ffira_pkg::ST_PLACED, last,
               "non-placement result without last mark")
  `ASSERT_IMPL(a_owner_only_on_read, strobe && status != ffira_pkg::ST_READ,
               owner_out == '0, "owner data on a non-read result")

endmodule
